### rtl/core/markup_glyph_blit_sequencer_assert.svh
// ----------------------------------------------------------------------------
// markup glyph blit sequencer assertion macros
// shared helpers for clocked checks held off during reset
// ----------------------------------------------------------------------------
`ifndef MARKUP_GLYPH_BLIT_SEQUENCER_ASSERT_SVH
`define MARKUP_GLYPH_BLIT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define MGBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mgbs check failed");

// next-cycle implication
`define MGBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mgbs check failed");

`endif

### rtl/core/mgbs_pkg.sv
// ----------------------------------------------------------------------------
// mgbs_pkg
// types and constants of the markup glyph blit sequencer
// ----------------------------------------------------------------------------
package mgbs_pkg;

  localparam int BYTE_W     = 8;
  localparam int MAP_ENTRIES = 256;
  localparam int MAP_IDX_W  = $clog2(MAP_ENTRIES);
  localparam int STYLE_W    = 7;
  localparam int ALPHA_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int POS_W      = 16;
  localparam int SRC_Y_W    = 14;

  localparam int DIV_W     = 8;
  localparam int DIVISOR_W = 7;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_LESS  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_TEXT   = 2'd1,
    CMD_MAP_WR = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH   = 3'd0,
    CFG_GLYPH_HEIGHT  = 3'd1,
    CFG_STYLE_COUNT   = 3'd2,
    CFG_GLYPH_OVERLAP = 3'd3,
    CFG_ALPHA_LEVELS  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [STYLE_W-1:0] style;
    logic [ALPHA_W-1:0] alpha;
  } attr_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

### rtl/core/mgbs_in_if.sv
// ----------------------------------------------------------------------------
// mgbs_in_if
// input channel: command beats with begin positions, text bytes and map writes
// ----------------------------------------------------------------------------
interface mgbs_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic [mgbs_pkg::BYTE_W-1:0]      text_byte;
  logic [mgbs_pkg::BYTE_W-1:0]      map_glyph;
  logic signed [mgbs_pkg::POS_W-1:0] start_x;
  logic signed [mgbs_pkg::POS_W-1:0] start_y;

  modport source (output valid, command, text_byte, map_glyph, start_x, start_y,
                  input ready);
  modport sink (input valid, command, text_byte, map_glyph, start_x, start_y,
                output ready);
endinterface

### rtl/core/mgbs_out_if.sv
// ----------------------------------------------------------------------------
// mgbs_out_if
// result channel: one glyph blit command per beat
// ----------------------------------------------------------------------------
interface mgbs_out_if;
  logic                               valid;
  logic                               ready;
  logic [mgbs_pkg::POS_W-1:0]         source_x;
  logic [mgbs_pkg::SRC_Y_W-1:0]       source_y;
  logic [mgbs_pkg::ALPHA_W-1:0]       alpha_plane;
  logic signed [mgbs_pkg::POS_W-1:0]  dest_x;
  logic signed [mgbs_pkg::POS_W-1:0]  dest_y;

  modport source (output valid, source_x, source_y, alpha_plane, dest_x, dest_y,
                  input ready);
  modport sink (input valid, source_x, source_y, alpha_plane, dest_x, dest_y,
                output ready);
endinterface

### rtl/core/markup_glyph_blit_sequencer.sv
// ----------------------------------------------------------------------------
// markup_glyph_blit_sequencer
// text bytes with caret escapes in, one glyph blit command per visible byte out
// ----------------------------------------------------------------------------
// timing depends on the input beat: begin, map write, plain caret and unused
// commands leave the sequencer idle; a visible glyph reads the glyph map, then
// does the multiplies into the output register, waiting while a previous
// result is still unaccepted; a pop reads the attribute stack, unless the
// stack is empty and it stays idle; a style or alpha push waits for the
// 8-step serial remainder unit. the glyph map reads as zero after reset
// through per-entry valid bits, so there is no clearing pass
`include "markup_glyph_blit_sequencer_assert.svh"

module markup_glyph_blit_sequencer #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mgbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mgbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  mgbs_in_if.sink                             in_ch,
  mgbs_out_if.source                          out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

  // configuration
  logic [7:0]                      glyph_width_r;
  logic [7:0]                      glyph_height_r;
  logic [mgbs_pkg::STYLE_W-1:0]    style_count_r;
  logic [7:0]                      glyph_overlap_r;
  logic [3:0]                      alpha_levels_r;

  // control
  mgbs_pkg::state_t                state_r, state_nxt;
  logic                            esc_r;
  logic [CNT_W-1:0]                cnt_r;
  mgbs_pkg::attr_t                 cur_r;
  logic [mgbs_pkg::POS_W-1:0]      pen_x_r;
  logic [mgbs_pkg::POS_W-1:0]      pen_y_r;
  logic                            out_valid_r;
  logic [mgbs_pkg::MAP_ENTRIES-1:0] map_vld_r;

  // storage and payload
  logic [7:0]                      map_mem [mgbs_pkg::MAP_ENTRIES];
  mgbs_pkg::attr_t                 stk_mem [STACK_DEPTH];
  logic [7:0]                      map_rd_r;
  logic                            map_rd_vld_r;
  mgbs_pkg::attr_t                 stk_rd_r;
  logic                            kind_alpha_r;
  logic [mgbs_pkg::POS_W-1:0]      src_x_r;
  logic [mgbs_pkg::SRC_Y_W-1:0]    src_y_r;
  logic [mgbs_pkg::ALPHA_W-1:0]    alpha_r;
  logic [mgbs_pkg::POS_W-1:0]      dst_x_r;
  logic [mgbs_pkg::POS_W-1:0]      dst_y_r;

  // decode
  logic                            in_fire;
  logic                            is_begin, is_text, is_map_wr;
  logic                            esc_set, do_pop, do_push, do_glyph;
  logic                            alpha_sel;
  logic [mgbs_pkg::BYTE_W-1:0]     tbyte;
  logic [CNT_W-1:0]                cnt_m1;
  logic                            stk_full;

  // sequencer outputs
  logic                            pop_en, push_en, emit_en;

  // shared unit
  mgbs_pkg::div_req_t              div_req;
  mgbs_pkg::div_rsp_t              div_rsp;

  // push and emit datapath
  logic                            mod_zero;
  logic [mgbs_pkg::STYLE_W-1:0]    push_val;
  mgbs_pkg::attr_t                 push_base;
  mgbs_pkg::attr_t                 push_attr;
  logic [7:0]                      glyph;
  logic [15:0]                     sx_prod;
  logic [14:0]                     sy_prod;

  assign tbyte     = in_ch.text_byte;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign is_begin  = in_fire && (in_ch.command == mgbs_pkg::CMD_BEGIN);
  assign is_text   = in_fire && (in_ch.command == mgbs_pkg::CMD_TEXT);
  assign is_map_wr = in_fire && (in_ch.command == mgbs_pkg::CMD_MAP_WR);
  assign esc_set   = is_text && !esc_r && (tbyte == mgbs_pkg::CH_CARET);
  assign do_pop    = is_text && esc_r && (tbyte == mgbs_pkg::CH_LESS);
  assign do_push   = is_text && esc_r && (tbyte != mgbs_pkg::CH_LESS) &&
                     (tbyte != mgbs_pkg::CH_CARET);
  assign do_glyph  = is_text && !esc_set && !do_pop && !do_push;
  assign alpha_sel = tbyte inside {[mgbs_pkg::CH_HASH:mgbs_pkg::CH_APOS]};
  assign cnt_m1    = cnt_r - 1'b1;
  assign stk_full  = (cnt_r == DEPTH_C);

  // shared remainder unit request
  always_comb begin
    div_req.start = do_push;
    if (alpha_sel) begin
      div_req.dividend = tbyte - mgbs_pkg::CH_HASH;
      div_req.divisor  = {{(mgbs_pkg::DIVISOR_W - 4){1'b0}}, alpha_levels_r};
    end else begin
      div_req.dividend = (tbyte >= mgbs_pkg::CH_ZERO) ? (tbyte - mgbs_pkg::CH_ZERO)
                                                      : (mgbs_pkg::CH_ZERO - tbyte);
      div_req.divisor  = style_count_r;
    end
  end

  mgbs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mgbs_pkg::ST_IDLE: begin
        if (do_pop && (cnt_r != '0)) begin
          state_nxt = mgbs_pkg::ST_POP;
        end else if (do_push) begin
          state_nxt = mgbs_pkg::ST_DIV;
        end else if (do_glyph) begin
          state_nxt = mgbs_pkg::ST_EMIT;
        end
      end
      mgbs_pkg::ST_POP: state_nxt = mgbs_pkg::ST_IDLE;
      mgbs_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = mgbs_pkg::ST_IDLE;
        end
      end
      mgbs_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = mgbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mgbs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    pop_en      = 1'b0;
    push_en     = 1'b0;
    emit_en     = 1'b0;
    case (state_r)
      mgbs_pkg::ST_IDLE: in_ch.ready = 1'b1;
      mgbs_pkg::ST_POP:  pop_en      = 1'b1;
      mgbs_pkg::ST_DIV:  push_en     = div_rsp.done;
      mgbs_pkg::ST_EMIT: emit_en     = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // push value; on a full stack the new attribute is built on the top entry and nothing is pushed
  always_comb begin
    mod_zero  = kind_alpha_r ? (alpha_levels_r == '0) : (style_count_r == '0);
    push_val  = mod_zero ? '0 : div_rsp.remainder;
    push_base = stk_full ? stk_rd_r : cur_r;
    push_attr = push_base;
    if (kind_alpha_r) begin
      push_attr.alpha = push_val[mgbs_pkg::ALPHA_W-1:0];
    end else begin
      push_attr.style = push_val;
    end
  end

  assign glyph   = map_rd_vld_r ? map_rd_r : 8'd0;
  assign sx_prod = {8'd0, glyph} * {8'd0, glyph_width_r};
  assign sy_prod = {8'd0, cur_r.style} * {7'd0, glyph_height_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r   <= 8'd8;
      glyph_height_r  <= 8'd8;
      style_count_r   <= 7'd1;
      glyph_overlap_r <= 8'd0;
      alpha_levels_r  <= 4'd1;
      state_r         <= mgbs_pkg::ST_IDLE;
      esc_r           <= 1'b0;
      cnt_r           <= '0;
      cur_r           <= '0;
      pen_x_r         <= '0;
      pen_y_r         <= '0;
      out_valid_r     <= 1'b0;
      map_vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mgbs_pkg::CFG_GLYPH_WIDTH:   glyph_width_r   <= cfg_wdata;
          mgbs_pkg::CFG_GLYPH_HEIGHT:  glyph_height_r  <= cfg_wdata;
          mgbs_pkg::CFG_STYLE_COUNT:   style_count_r   <= cfg_wdata[mgbs_pkg::STYLE_W-1:0];
          mgbs_pkg::CFG_GLYPH_OVERLAP: glyph_overlap_r <= cfg_wdata;
          mgbs_pkg::CFG_ALPHA_LEVELS:  alpha_levels_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (is_begin) begin
        pen_x_r <= in_ch.start_x;
        pen_y_r <= in_ch.start_y;
        cnt_r   <= '0;
        cur_r   <= '0;
        esc_r   <= 1'b0;
      end else if (is_text) begin
        esc_r <= esc_set;
      end
      if (is_map_wr) begin
        map_vld_r[tbyte] <= 1'b1;
      end
      if (pop_en) begin
        cur_r <= stk_rd_r;
        cnt_r <= cnt_m1;
      end
      if (push_en) begin
        cur_r <= push_attr;
        if (!stk_full) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (emit_en) begin
        pen_x_r <= pen_x_r + {8'd0, glyph_width_r} - {8'd0, glyph_overlap_r};
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories and payload
  always_ff @(posedge clk) begin
    if (is_map_wr) begin
      map_mem[tbyte] <= in_ch.map_glyph;
    end
    if (in_fire) begin
      map_rd_r     <= map_mem[tbyte];
      map_rd_vld_r <= map_vld_r[tbyte];
      kind_alpha_r <= alpha_sel;
    end
    if (push_en && !stk_full) begin
      stk_mem[cnt_r[IDX_W-1:0]] <= cur_r;
    end
    stk_rd_r <= stk_mem[cnt_m1[IDX_W-1:0]];
    if (emit_en) begin
      src_x_r <= sx_prod;
      src_y_r <= sy_prod[mgbs_pkg::SRC_Y_W-1:0];
      alpha_r <= cur_r.alpha;
      dst_x_r <= pen_x_r;
      dst_y_r <= pen_y_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.source_x    = src_x_r;
  assign out_ch.source_y    = src_y_r;
  assign out_ch.alpha_plane = alpha_r;
  assign out_ch.dest_x      = dst_x_r;
  assign out_ch.dest_y      = dst_y_r;

  `MGBS_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= DEPTH_C)
  `MGBS_ASSERT_IMPLY(a_div_done_in_div, clk, rst_n, div_rsp.done,
                     state_r == mgbs_pkg::ST_DIV)
  `MGBS_ASSERT_NEXT(a_emit_waits, clk, rst_n,
                    (state_r == mgbs_pkg::ST_EMIT) && out_valid_r && !out_ch.ready,
                    (state_r == mgbs_pkg::ST_EMIT) && out_valid_r)
  `MGBS_ASSERT_NEXT(a_pen_hold, clk, rst_n, !is_begin && !emit_en, $stable(pen_x_r))

endmodule

### rtl/core/mgbs_divider.sv
// ----------------------------------------------------------------------------
// mgbs_divider
// serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module mgbs_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  mgbs_pkg::div_req_t req,
  output mgbs_pkg::div_rsp_t rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [mgbs_pkg::STEP_W-1:0]         step_r;
  logic [mgbs_pkg::DIV_W-1:0]          dvd_r;
  logic [mgbs_pkg::DIVISOR_W-1:0]      dvs_r;
  logic [mgbs_pkg::DIV_W-1:0]          rem_r;
  logic [mgbs_pkg::DIV_W:0]            trial;
  logic [mgbs_pkg::DIV_W-1:0]          rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[mgbs_pkg::DIV_W-1]};
    if (trial >= {{(mgbs_pkg::DIV_W + 1 - mgbs_pkg::DIVISOR_W){1'b0}}, dvs_r}) begin
      rem_nxt = mgbs_pkg::DIV_W'(trial - {{(mgbs_pkg::DIV_W + 1 - mgbs_pkg::DIVISOR_W){1'b0}},
                                          dvs_r});
    end else begin
      rem_nxt = trial[mgbs_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == mgbs_pkg::DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[mgbs_pkg::DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r[mgbs_pkg::DIVISOR_W-1:0];

endmodule
